// ----- rtl/core/glmf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package glmf_pkg;

  // Grid geometry
  localparam int unsigned MaxGridDefault = 128;
  localparam int unsigned MinGrid        = 2;
  localparam int unsigned GridSizeW      = 8;
  localparam int unsigned GridSizeReset  = 100;

  // Field widths
  localparam int unsigned HeightW = 4;
  localparam int unsigned CoordW  = 7;
  localparam int unsigned RiskW   = 18;

  localparam logic [RiskW-1:0]   RiskMax      = '1;
  localparam logic [HeightW-1:0] BorderHeight = HeightW'(10);

  // Front-to-back queue
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned SlotsPerItem = 3;

  // Number of results one queue entry holds
  typedef logic [1:0] slot_cnt_t;

  localparam slot_cnt_t CntNone  = 2'd0;
  localparam slot_cnt_t CntAbove = 2'd1;
  localparam slot_cnt_t CntLeft  = 2'd2;
  localparam slot_cnt_t CntFinal = 2'd3;

  // Slot positions inside an entry, in raster order of the decided cells
  localparam slot_cnt_t SlotAbove = 2'd0;  // cell one row up, same column
  localparam slot_cnt_t SlotLeft  = 2'd1;  // last row, cell to the left
  localparam slot_cnt_t SlotFinal = 2'd2;  // last cell of the grid

  typedef struct packed {
    logic [CoordW-1:0]  row;
    logic [CoordW-1:0]  col;
    logic [HeightW-1:0] height;
    logic               low;
    logic               done;
  } decision_t;

  typedef struct packed {
    slot_cnt_t                        cnt;
    decision_t [SlotsPerItem-1:0]     slot;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/glmf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glmf_queue import glmf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire entry_t    entry_i,
  input  wire logic      pop_i,
  output entry_t         entry_o,
  output q_status_t      status_o
);

  entry_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   do_push, do_pop;

  assign status_o.full  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign status_o.empty = (count_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign entry_o = mem_q[rd_ptr_q];

  // Pointer and fill level
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/glmf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glmf_front import glmf_pkg::*; #(
  parameter int unsigned MAX_GRID = MaxGridDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [GridSizeW-1:0]  cfg_size_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [HeightW-1:0]    height_i,
  input  wire q_status_t             q_stat_i,
  output logic                       push_o,
  output entry_t                     entry_o
);

  localparam int unsigned CW = $clog2(MAX_GRID);
  localparam int unsigned GW = (CW + 1 > GridSizeW) ? CW + 1 : GridSizeW;
  localparam int unsigned SizeResetClamp =
      (GridSizeReset > MAX_GRID) ? MAX_GRID : GridSizeReset;
  localparam logic [CW-1:0] LastReset = CW'(SizeResetClamp - 1);

  logic [CW-1:0]      last_q;
  logic [CW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic [GW-1:0]      size_ext, size_clamped;
  logic [CW-1:0]      cfg_last;
  logic               accept;
  logic               col_end, row_end;
  logic               has_above, has_left, has_final;

  // Line buffers: upper holds row r-2, middle holds row r-1 (and row r behind col)
  logic [HeightW-1:0] upper_mem  [MAX_GRID];
  logic [HeightW-1:0] middle_mem [MAX_GRID];
  logic [CW-1:0]      rd_addr, rd_addr_nx;
  logic [HeightW-1:0] up_rd_q;    // upper[c]
  logic [HeightW-1:0] mid_rd_q;   // middle[c]
  logic [HeightW-1:0] nxt_rd_q;   // middle[c+1]

  // Recent history along the current row
  logic [HeightW-1:0] prev_mid_q; // middle[c-1] of the row above
  logic [HeightW-1:0] prev_h_q;   // input at c-1
  logic [HeightW-1:0] prev2_h_q;  // input at c-2

  logic [HeightW-1:0] a_up, a_left, a_right;
  logic [HeightW-1:0] b_left;

  function automatic logic below_all(input logic [HeightW-1:0] v,
                                     input logic [HeightW-1:0] up,
                                     input logic [HeightW-1:0] dn,
                                     input logic [HeightW-1:0] lf,
                                     input logic [HeightW-1:0] rt);
    return (v < up) && (v < dn) && (v < lf) && (v < rt);
  endfunction

  // Grid size clamp, kept as index of the last row/column
  always_comb begin
    size_ext = GW'(cfg_size_i);
    if (size_ext < GW'(MinGrid)) begin
      size_clamped = GW'(MinGrid);
    end else if (size_ext > GW'(MAX_GRID)) begin
      size_clamped = GW'(MAX_GRID);
    end else begin
      size_clamped = size_ext;
    end
  end
  assign cfg_last = CW'(size_clamped - GW'(1));

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign col_end   = (col_q == last_q);
  assign row_end   = (row_q == last_q);
  assign has_above = (row_q != '0);
  assign has_left  = row_end && (col_q != '0);
  assign has_final = row_end && col_end;

  // Raster counters
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= LastReset;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        last_q <= cfg_last;
      end
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Line buffer update and prefetch for the next column, with write bypass
  assign rd_addr    = col_d;
  assign rd_addr_nx = col_d + 1'b1;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_mem[col_q]  <= mid_rd_q;
      middle_mem[col_q] <= height_i;
    end
    up_rd_q  <= (accept && rd_addr == col_q)    ? mid_rd_q : upper_mem[rd_addr];
    mid_rd_q <= (accept && rd_addr == col_q)    ? height_i : middle_mem[rd_addr];
    nxt_rd_q <= (accept && rd_addr_nx == col_q) ? height_i : middle_mem[rd_addr_nx];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_mid_q <= mid_rd_q;
      prev_h_q   <= height_i;
      prev2_h_q  <= prev_h_q;
    end
  end

  // Neighbours with the border folded in
  assign a_up    = (row_q == CW'(1)) ? BorderHeight : up_rd_q;
  assign a_left  = (col_q == '0)     ? BorderHeight : prev_mid_q;
  assign a_right = col_end           ? BorderHeight : nxt_rd_q;
  assign b_left  = (col_q == CW'(1)) ? BorderHeight : prev2_h_q;

  // Classify the cells this input decides
  always_comb begin
    entry_o = '0;

    entry_o.slot[SlotAbove].row    = CoordW'(row_q - 1'b1);
    entry_o.slot[SlotAbove].col    = CoordW'(col_q);
    entry_o.slot[SlotAbove].height = mid_rd_q;
    entry_o.slot[SlotAbove].low    = below_all(mid_rd_q, a_up, height_i, a_left, a_right);
    entry_o.slot[SlotAbove].done   = 1'b0;

    entry_o.slot[SlotLeft].row     = CoordW'(row_q);
    entry_o.slot[SlotLeft].col     = CoordW'(col_q - 1'b1);
    entry_o.slot[SlotLeft].height  = prev_h_q;
    entry_o.slot[SlotLeft].low     = below_all(prev_h_q, prev_mid_q, BorderHeight,
                                               b_left, height_i);
    entry_o.slot[SlotLeft].done    = 1'b0;

    entry_o.slot[SlotFinal].row    = CoordW'(row_q);
    entry_o.slot[SlotFinal].col    = CoordW'(col_q);
    entry_o.slot[SlotFinal].height = height_i;
    entry_o.slot[SlotFinal].low    = below_all(height_i, mid_rd_q, BorderHeight,
                                               prev_h_q, BorderHeight);
    entry_o.slot[SlotFinal].done   = 1'b1;

    if (has_final) begin
      entry_o.cnt = CntFinal;
    end else if (has_left) begin
      entry_o.cnt = CntLeft;
    end else if (has_above) begin
      entry_o.cnt = CntAbove;
    end else begin
      entry_o.cnt = CntNone;
    end
  end

  // Row zero decides nothing and stays out of the queue
  assign push_o = accept && has_above;

endmodule

`default_nettype wire

// ----- rtl/core/glmf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glmf_back import glmf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire q_status_t            q_stat_i,
  input  wire entry_t               entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [CoordW-1:0]         cell_row_o,
  output logic [CoordW-1:0]         cell_col_o,
  output logic [HeightW-1:0]        cell_height_o,
  output logic                      is_low_o,
  output logic [RiskW-1:0]          risk_total_o,
  output logic                      grid_done_o,
  output logic                      last_o
);

  logic               out_valid_q, out_valid_d;
  slot_cnt_t          idx_q, idx_d;
  logic [RiskW-1:0]   risk_q, risk_d;
  logic               load;
  decision_t          cur;
  logic               final_slot;
  logic [RiskW:0]     risk_inc;
  logic [RiskW-1:0]   risk_sat, risk_new;

  logic [CoordW-1:0]  row_q, col_q;
  logic [HeightW-1:0] height_q;
  logic               low_q, done_q, last_q;
  logic [RiskW-1:0]   total_q;

  // Output register takes a new result when empty or being drained
  assign load       = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign cur        = entry_i.slot[idx_q];
  assign final_slot = (idx_q == slot_cnt_t'(entry_i.cnt - 1'b1));
  assign pop_o      = load && final_slot;

  // Saturating risk accumulation
  assign risk_inc = {1'b0, risk_q} + (RiskW+1)'(cur.height) + (RiskW+1)'(1);
  assign risk_sat = (risk_inc > {1'b0, RiskMax}) ? RiskMax : risk_inc[RiskW-1:0];
  assign risk_new = cur.low ? risk_sat : risk_q;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    risk_d      = risk_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = final_slot ? SlotAbove : idx_q + 1'b1;
      risk_d      = cur.done ? '0 : risk_new;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      risk_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= SlotAbove;
      risk_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      risk_q      <= risk_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q    <= cur.row;
      col_q    <= cur.col;
      height_q <= cur.height;
      low_q    <= cur.low;
      done_q   <= cur.done;
      last_q   <= final_slot;
      total_q  <= risk_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_row_o    = row_q;
  assign cell_col_o    = col_q;
  assign cell_height_o = height_q;
  assign is_low_o      = low_q;
  assign risk_total_o  = total_q;
  assign grid_done_o   = done_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/grid_local_minimum_finder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake      | Payload
// in      | input     | valid / stall  | height_i
// out     | output    | valid / stall  | cell_row_o, cell_col_o, cell_height_o, is_low_o,
//         |           |                | risk_total_o, grid_done_o, last_o
// cfg     | input     | valid / ready  | cfg_data_i (grid size)
//
// One cell is accepted per cycle while the four-entry queue has room; the first result
// of a cell passes through the queue and then the output register.
// Results leave one per cycle from the output register while out_stall_i is low, so on
// the last row (up to three results per cell) throughput is set by that register.
// Reset clears counters, risk sum and queue; the line buffers are not cleared.
// in_stall_o is high while the queue is full; cfg_ready_o is high when no work is pending.

module grid_local_minimum_finder_unit import glmf_pkg::*; #(
  parameter int unsigned MAX_GRID = MaxGridDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [GridSizeW-1:0]  cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [HeightW-1:0]    height_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [CoordW-1:0]          cell_row_o,
  output logic [CoordW-1:0]          cell_col_o,
  output logic [HeightW-1:0]         cell_height_o,
  output logic                       is_low_o,
  output logic [RiskW-1:0]           risk_total_o,
  output logic                       grid_done_o,
  output logic                       last_o
);

  q_status_t q_stat;
  entry_t    push_entry, head_entry;
  logic      push, pop;
  logic      cfg_we;

  // Configuration is taken only with nothing in flight
  assign cfg_ready_o = q_stat.empty && !out_valid_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  glmf_front #(
    .MAX_GRID (MAX_GRID)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_size_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .height_i   (height_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  glmf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_stat)
  );

  glmf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .q_stat_i      (q_stat),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_row_o    (cell_row_o),
    .cell_col_o    (cell_col_o),
    .cell_height_o (cell_height_o),
    .is_low_o      (is_low_o),
    .risk_total_o  (risk_total_o),
    .grid_done_o   (grid_done_o),
    .last_o        (last_o)
  );

`ifndef ASSERT_OFF
  // A full queue means the back end already holds a result
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // A config write happens idle, so no result follows right away
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !out_valid_o)
    else $error("result appeared right after a config write");

  // Within a grid the risk total never decreases between back-to-back results
  a_risk_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !grid_done_o) ##1 out_valid_o
      |-> risk_total_o >= $past(risk_total_o))
    else $error("risk total decreased inside a grid");

  // A low point always leaves a nonzero risk total
  a_low_adds_risk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_low_o |-> risk_total_o != '0)
    else $error("low point reported with zero risk");
`endif

endmodule

`default_nettype wire

// ----- test/grid_local_minimum_finder_unit_test.sv -----
`timescale 1ns / 1ps

module grid_local_minimum_finder_unit_test;
  import glmf_pkg::*;

  localparam int unsigned GridCap      = MaxGridDefault;
  localparam int unsigned RiskCeil     = (1 << RiskW) - 1;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned RandomCells  = 400;
  localparam int unsigned ReportLimit  = 10;

  typedef struct packed {
    logic [CoordW-1:0]  row;
    logic [CoordW-1:0]  col;
    logic [HeightW-1:0] height;
    logic               low;
    logic [RiskW-1:0]   risk;
    logic               done;
    logic               last;
  } cell_result_t;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;
  typedef enum logic {RowConfig, RowCell} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [GridSizeW-1:0]   value;
    logic                   typed;
    cell_result_t           want;
  } stim_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [GridSizeW-1:0]  cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic [HeightW-1:0]    height_i    = '0;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [CoordW-1:0]     cell_row_o;
  logic [CoordW-1:0]     cell_col_o;
  logic [HeightW-1:0]    cell_height_o;
  logic                  is_low_o;
  logic [RiskW-1:0]      risk_total_o;
  logic                  grid_done_o;
  logic                  last_o;

  // Predictor state: two line buffers, raster position, risk sum, grid size
  logic [HeightW-1:0]    upper_hts  [GridCap];
  logic [HeightW-1:0]    middle_hts [GridCap];
  int unsigned           row_pos;
  int unsigned           col_pos;
  int unsigned           risk_acc;
  logic [GridSizeW-1:0]  size_reg;

  cell_result_t          pending_cells[$];
  int unsigned           mismatches = 0;
  idle_mode_e            idle_mode  = IdleNone;

  grid_local_minimum_finder_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .height_i     (height_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_row_o   (cell_row_o),
    .cell_col_o   (cell_col_o),
    .cell_height_o(cell_height_o),
    .is_low_o     (is_low_o),
    .risk_total_o (risk_total_o),
    .grid_done_o  (grid_done_o),
    .last_o       (last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Active grid edge length, clamped to the supported range
  function automatic int unsigned grid_dim();
    int unsigned g;
    g = size_reg;
    if (g < MinGrid) g = MinGrid;
    if (g > GridCap) g = GridCap;
    return g;
  endfunction

  // Decide one cell against its four neighbors; bumps the risk sum on a low point
  function automatic cell_result_t judge_cell(int unsigned r, int unsigned c,
                                              int unsigned val, int unsigned up,
                                              int unsigned down, int unsigned left,
                                              int unsigned right, logic done);
    cell_result_t res;
    res.low = (val < up) && (val < down) && (val < left) && (val < right);
    if (res.low) begin
      risk_acc += val + 1;
      if (risk_acc > RiskCeil) risk_acc = RiskCeil;
    end
    res.row    = CoordW'(r);
    res.col    = CoordW'(c);
    res.height = HeightW'(val);
    res.risk   = RiskW'(risk_acc);
    res.done   = done;
    res.last   = 1'b0;
    return res;
  endfunction

  // One accepted cell: decided cells in raster order, then buffer and counter update
  task automatic predict_cell(input logic [HeightW-1:0] h, output cell_result_t res[3],
                              output int n);
    int unsigned g, r, c, last_idx;
    g = grid_dim();
    r = row_pos;
    c = col_pos;
    n = 0;
    if (r >= g || c >= g) begin
      r = 0;
      c = 0;
    end
    last_idx = g - 1;
    // cell straight above is now complete
    if (r >= 1) begin
      res[n] = judge_cell(r - 1, c, middle_hts[c],
                          (r == 1) ? BorderHeight : upper_hts[c], h,
                          (c == 0) ? BorderHeight : upper_hts[c - 1],
                          (c == last_idx) ? BorderHeight : middle_hts[c + 1], 1'b0);
      n++;
    end
    // bottom row: left neighbor has its right side now
    if (r == last_idx && c >= 1) begin
      res[n] = judge_cell(r, c - 1, middle_hts[c - 1], upper_hts[c - 1], BorderHeight,
                          (c == 1) ? BorderHeight : middle_hts[c - 2], h, 1'b0);
      n++;
    end
    // final cell decides itself
    if (r == last_idx && c == last_idx) begin
      res[n] = judge_cell(r, c, h, middle_hts[c], BorderHeight, middle_hts[c - 1],
                          BorderHeight, 1'b1);
      n++;
    end
    if (n > 0) res[n - 1].last = 1'b1;

    upper_hts[c]  = middle_hts[c];
    middle_hts[c] = h;

    if (r == last_idx && c == last_idx) begin
      row_pos  = 0;
      col_pos  = 0;
      risk_acc = 0;
    end else if (c == last_idx) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  function automatic bit sender_rests();
    case (idle_mode)
      IdleSender: return $urandom_range(99, 0) < 87;
      IdleBoth:   return $urandom_range(99, 0) < 11;
      default:    return 1'b0;
    endcase
  endfunction

  // Mostly proper digits, occasionally an out-of-range height
  function automatic logic [HeightW-1:0] rand_height();
    if ($urandom_range(11, 0) == 0) return HeightW'($urandom_range(15, 10));
    return HeightW'($urandom_range(9, 0));
  endfunction

  // Drop valid and hold off until every outstanding result has been seen
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_cells.size() != 0) @(negedge clk_i);
  endtask

  // Push one cell; queue the predicted results, or the typed one for checked rows
  task automatic send_cell(input logic [HeightW-1:0] h, input logic typed,
                           input cell_result_t want);
    cell_result_t got[3];
    int n;
    @(negedge clk_i);
    while (sender_rests()) begin
      in_valid_i = 1'b0;
      height_i   = HeightW'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    height_i   = h;
    do @(posedge clk_i); while (in_stall_o);
    predict_cell(h, got, n);
    if (typed) begin
      pending_cells.insert(pending_cells.size(), want);
    end else begin
      for (int i = 0; i < n; i++) pending_cells.insert(pending_cells.size(), got[i]);
    end
  endtask

  // Grid size write, only once the block has gone quiet
  task automatic write_size(input logic [GridSizeW-1:0] v);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_reg = v;
    row_pos  = 0;
    col_pos  = 0;
    risk_acc = 0;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = GridSizeW'($urandom);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    case (idle_mode)
      IdleReceiver: out_stall_i <= ($urandom_range(99, 0) < 87);
      IdleBoth:     out_stall_i <= ($urandom_range(99, 0) < 11);
      default:      out_stall_i <= 1'b0;
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    cell_result_t seen;
    cell_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.row    = cell_row_o;
      seen.col    = cell_col_o;
      seen.height = cell_height_o;
      seen.low    = is_low_o;
      seen.risk   = risk_total_o;
      seen.done   = grid_done_o;
      seen.last   = last_o;
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t unexpected row %0d col %0d h %0d low %0d risk %0d done %0d last %0d",
                   $realtime, seen.row, seen.col, seen.height, seen.low, seen.risk,
                   seen.done, seen.last);
      end else begin
        want = pending_cells.pop_front();
        if (seen.row !== want.row || seen.col !== want.col || seen.height !== want.height ||
            seen.low !== want.low || seen.risk !== want.risk || seen.done !== want.done ||
            seen.last !== want.last) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t exp row %0d col %0d h %0d low %0d risk %0d done %0d last %0d",
                     $realtime, want.row, want.col, want.height, want.low, want.risk,
                     want.done, want.last);
            $display("%0t got row %0d col %0d h %0d low %0d risk %0d done %0d last %0d",
                     $realtime, seen.row, seen.col, seen.height, seen.low, seen.risk,
                     seen.done, seen.last);
          end
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t             directed[$];
    stim_row_t             row;
    int unsigned           phase;
    int unsigned           sent;
    int unsigned           count;
    int unsigned           dim;
    logic [GridSizeW-1:0]  size_val;

    size_reg = GridSizeW'(GridSizeReset);
    row_pos  = 0;
    col_pos  = 0;
    risk_acc = 0;

    // 2x2 grid: corner low point, then a grid closed by the final cell
    directed.insert(directed.size(), '{RowConfig, 8'd0, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd0, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd9, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd9, 1'b1,
                    '{row: 0, col: 0, height: 0, low: 1, risk: 1, done: 0, last: 1}});
    directed.insert(directed.size(), '{RowCell, 8'd9, 1'b0, '0});
    // heights above 9 stay above the border, a zero in the final corner
    directed.insert(directed.size(), '{RowCell, 8'd15, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd15, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd15, 1'b1,
                    '{row: 0, col: 0, height: 15, low: 0, risk: 0, done: 0, last: 1}});
    directed.insert(directed.size(), '{RowCell, 8'd0, 1'b0, '0});
    // size one clamps to two; diagonal lows
    directed.insert(directed.size(), '{RowConfig, 8'd1, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd9, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd0, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd0, 1'b0, '0});
    directed.insert(directed.size(), '{RowCell, 8'd9, 1'b0, '0});
    // 3x3 grid with a single center low and ties on the rim
    directed.insert(directed.size(), '{RowConfig, 8'd3, 1'b0, '0});
    for (int i = 0; i < 9; i++)
      directed.insert(directed.size(), '{RowCell, (i == 4) ? 8'd0 : 8'd5, 1'b0, '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset grid size: first row plus one cell, one decision out
    idle_mode = IdleBoth;
    for (int i = 0; i <= GridSizeReset; i++) send_cell(rand_height(), 1'b0, '0);

    idle_mode = IdleNone;
    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == RowConfig) write_size(row.value);
      else send_cell(row.value[HeightW-1:0], row.typed, row.want);
    end

    // random phases: mostly whole small grids, a few wide partial ones
    phase = 0;
    sent  = 0;
    while (sent < RandomCells || phase < 5) begin
      idle_mode = idle_mode_e'(phase % 4);
      case (phase)
        1: begin
          size_val = 8'd255;
          count    = GridCap + 2;
        end
        4: begin
          size_val = GridSizeW'(GridCap);
          count    = 2 * GridCap;
        end
        default: begin
          size_val = GridSizeW'($urandom_range(9, 0));
          dim      = (size_val < MinGrid) ? MinGrid : size_val;
          count    = dim * dim;
          // abandon a grid partway now and then
          if ($urandom_range(4, 0) == 0) count = $urandom_range(dim * dim - 1, 1);
        end
      endcase
      write_size(size_val);
      for (int i = 0; i < count; i++) begin
        if (phase % 3 == 0 && i == count / 2) wait_drained();
        send_cell(rand_height(), 1'b0, '0);
      end
      sent += count;
      phase++;
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/glmf_pkg.sv
rtl/core/glmf_queue.sv
rtl/core/glmf_front.sv
rtl/core/glmf_back.sv
rtl/core/grid_local_minimum_finder_unit.sv
test/grid_local_minimum_finder_unit_test.sv
